[rtl/core/mvt4_pkg.sv]
// Package for the 4x4 matrix-vector transform: shared lane widths, register
// indexes and the lane result record. No dependencies.
package mvt4_pkg;

  localparam int NUM_LANES       = 4;
  localparam int LANE_BITS       = 16;
  localparam int COLUMN_BITS     = NUM_LANES * LANE_BITS;
  localparam int CFG_INDEX_WIDTH = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MATRIX_COLUMN_0 = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MATRIX_COLUMN_1 = 8'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MATRIX_COLUMN_2 = 8'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MATRIX_COLUMN_3 = 8'd3;

  typedef logic [NUM_LANES-1:0][LANE_BITS-1:0] lane_vec_t;

  typedef struct packed {
    logic [LANE_BITS-1:0] value;
    logic                 sat;
  } lane_out_t;

endpackage

[rtl/core/mvt4_lane.sv]
// One row lane of the transform: four products, then sum, round and saturate.
// Depends on mvt4_pkg.
module mvt4_lane #(
  parameter int ELEMENT_WIDTH = 16,
  parameter int FRACTION_BITS = 12
) (
  input  logic                clk,
  input  logic                load,
  input  logic                finish,
  input  mvt4_pkg::lane_vec_t vec,
  input  mvt4_pkg::lane_vec_t coef,
  output mvt4_pkg::lane_out_t result
);

  localparam int PROD_W = 2 * ELEMENT_WIDTH;
  localparam int SUM_W  = 2 * ELEMENT_WIDTH + 2;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRACTION_BITS - 1);
  localparam logic signed [SUM_W-1:0] HI_LIMIT =
    SUM_W'((longint'(1) << (ELEMENT_WIDTH - 1)) - 1);
  localparam logic signed [SUM_W-1:0] LO_LIMIT = ~HI_LIMIT;

  logic signed [ELEMENT_WIDTH-1:0] vec_elem  [mvt4_pkg::NUM_LANES];
  logic signed [ELEMENT_WIDTH-1:0] coef_elem [mvt4_pkg::NUM_LANES];
  logic signed [PROD_W-1:0]        prod      [mvt4_pkg::NUM_LANES];
  logic signed [SUM_W-1:0]         sum;
  logic signed [SUM_W-1:0]         shifted;
  logic signed [ELEMENT_WIDTH-1:0] clipped;
  logic                            over;
  logic                            under;

  // Keep the low element bits of each 16-bit lane, signed.
  always_comb begin
    for (int j = 0; j < mvt4_pkg::NUM_LANES; j++) begin
      vec_elem[j]  = vec[j][ELEMENT_WIDTH-1:0];
      coef_elem[j] = coef[j][ELEMENT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < mvt4_pkg::NUM_LANES; j++) begin
        prod[j] <= vec_elem[j] * coef_elem[j];
      end
    end
  end

  // Exact sum, round half up, arithmetic shift, clamp.
  always_comb begin
    sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(prod[3]);
    shifted = (sum + ROUND_HALF) >>> FRACTION_BITS;
    over  = shifted > HI_LIMIT;
    under = shifted < LO_LIMIT;
    if (over) begin
      clipped = HI_LIMIT[ELEMENT_WIDTH-1:0];
    end else if (under) begin
      clipped = LO_LIMIT[ELEMENT_WIDTH-1:0];
    end else begin
      clipped = shifted[ELEMENT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.value <= mvt4_pkg::LANE_BITS'(clipped);
      result.sat   <= over | under;
    end
  end

endmodule

[rtl/core/mvt4_merge.sv]
// Merge stage: gathers the four lane results into one output beat and folds
// the lane saturation flags. Depends on mvt4_pkg.
module mvt4_merge (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  mvt4_pkg::lane_out_t          lanes [mvt4_pkg::NUM_LANES],
  output logic                         done,
  output logic [mvt4_pkg::LANE_BITS-1:0] out_x,
  output logic [mvt4_pkg::LANE_BITS-1:0] out_y,
  output logic [mvt4_pkg::LANE_BITS-1:0] out_z,
  output logic [mvt4_pkg::LANE_BITS-1:0] out_w,
  output logic                         saturated
);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_x     <= lanes[0].value;
      out_y     <= lanes[1].value;
      out_z     <= lanes[2].value;
      out_w     <= lanes[3].value;
      saturated <= lanes[0].sat | lanes[1].sat | lanes[2].sat | lanes[3].sat;
    end
  end

endmodule

[rtl/core/matrix_vector_transform_4x4_unit.sv]
// Result: an accepted beat comes out with done high from the merge output register.
// One beat per cycle while not busy; start may be held high every cycle, results never stall.
// Stages: product registers in each row lane, sum/round/clamp register, merge output register.
// Reset: synchronous rst restores the identity matrix and drops every beat in flight.
// busy is high during reset and in the cycle after it; otherwise low.
// Depends on mvt4_pkg, mvt4_lane, mvt4_merge.
module matrix_vector_transform_4x4_unit #(
  parameter int ELEMENT_WIDTH = 16,
  parameter int FRACTION_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mvt4_pkg::LANE_BITS-1:0]       vec_x,
  input  logic [mvt4_pkg::LANE_BITS-1:0]       vec_y,
  input  logic [mvt4_pkg::LANE_BITS-1:0]       vec_z,
  input  logic [mvt4_pkg::LANE_BITS-1:0]       vec_w,
  // Result strobe
  output logic                                 done,
  output logic [mvt4_pkg::LANE_BITS-1:0]       out_x,
  output logic [mvt4_pkg::LANE_BITS-1:0]       out_y,
  output logic [mvt4_pkg::LANE_BITS-1:0]       out_z,
  output logic [mvt4_pkg::LANE_BITS-1:0]       out_w,
  output logic                                 saturated,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mvt4_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mvt4_pkg::COLUMN_BITS-1:0]     cfg_data
);

  localparam int LB = mvt4_pkg::LANE_BITS;
  localparam int NL = mvt4_pkg::NUM_LANES;

  // Identity element: 1.0 in the chosen fixed-point format.
  localparam logic [mvt4_pkg::COLUMN_BITS-1:0] ONE =
    mvt4_pkg::COLUMN_BITS'(1) << FRACTION_BITS;

  logic                               busy_hold;
  logic                               accept;
  logic                               stage1_valid;
  logic                               stage2_valid;
  logic [mvt4_pkg::COLUMN_BITS-1:0]   matrix_col [NL];
  mvt4_pkg::lane_vec_t                vec;
  mvt4_pkg::lane_vec_t                row_coef [NL];
  mvt4_pkg::lane_out_t                lane_res [NL];

  // Hold off commands and config during reset and the cycle after it.
  always_ff @(posedge clk) begin
    busy_hold <= rst;
  end

  assign busy      = rst | busy_hold;
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  // Matrix registers; writes to indexes beyond the four columns drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NL; j++) begin
        matrix_col[j] <= ONE << (j * LB);
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mvt4_pkg::CFG_MATRIX_COLUMN_0: matrix_col[0] <= cfg_data;
        mvt4_pkg::CFG_MATRIX_COLUMN_1: matrix_col[1] <= cfg_data;
        mvt4_pkg::CFG_MATRIX_COLUMN_2: matrix_col[2] <= cfg_data;
        mvt4_pkg::CFG_MATRIX_COLUMN_3: matrix_col[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Advance the valid marks alongside the lane data.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      stage2_valid <= 1'b0;
    end else begin
      stage1_valid <= accept;
      stage2_valid <= stage1_valid;
    end
  end

  // Every lane sees the whole vector; lane r sees row r of each column.
  always_comb begin
    vec[0] = vec_x;
    vec[1] = vec_y;
    vec[2] = vec_z;
    vec[3] = vec_w;
    for (int r = 0; r < NL; r++) begin
      for (int j = 0; j < NL; j++) begin
        row_coef[r][j] = matrix_col[j][r*LB +: LB];
      end
    end
  end

  for (genvar r = 0; r < NL; r++) begin : g_lane
    mvt4_lane #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk    (clk),
      .load   (accept),
      .finish (stage1_valid),
      .vec    (vec),
      .coef   (row_coef[r]),
      .result (lane_res[r])
    );
  end

  mvt4_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage2_valid),
    .lanes     (lane_res),
    .done      (done),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .saturated (saturated)
  );

endmodule

[rtl/core/mvt4_checker.sv]
// Port-level checker for the 4x4 transform unit and its bind.
// Depends on matrix_vector_transform_4x4_unit.
module mvt4_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_ready
);

  // Every accepted beat yields a result strobe once through the pipeline registers.
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted beat produced no result");

  // No result strobe without a matching accepted beat.
  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without an accepted beat");

  // Reset drops beats in flight and holds off commands.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> (!done && busy))
    else $error("reset did not flush or hold off");

  // Config ready tracks command availability.
  a_cfg_ready: assert property (@(posedge clk)
    cfg_ready != busy)
    else $error("config ready out of step with busy");

endmodule

bind matrix_vector_transform_4x4_unit mvt4_checker u_mvt4_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .cfg_ready (cfg_ready)
);

[tb/mvt4_transform_checker.sv]
`timescale 1ns / 100ps
// Result checker for matrix_vector_transform_4x4_unit: keeps its own copy of
// the matrix from config beats, predicts each transform, compares done beats.
// Depends on mvt4_pkg.
module mvt4_transform_checker #(
  parameter int ELEMENT_WIDTH = 16,
  parameter int FRACTION_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [mvt4_pkg::LANE_BITS-1:0]       vec_x,
  input  logic [mvt4_pkg::LANE_BITS-1:0]       vec_y,
  input  logic [mvt4_pkg::LANE_BITS-1:0]       vec_z,
  input  logic [mvt4_pkg::LANE_BITS-1:0]       vec_w,
  input  logic                                 done,
  input  logic [mvt4_pkg::LANE_BITS-1:0]       out_x,
  input  logic [mvt4_pkg::LANE_BITS-1:0]       out_y,
  input  logic [mvt4_pkg::LANE_BITS-1:0]       out_z,
  input  logic [mvt4_pkg::LANE_BITS-1:0]       out_w,
  input  logic                                 saturated,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [mvt4_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mvt4_pkg::COLUMN_BITS-1:0]     cfg_data,
  output int                                   pending,
  output int                                   fail_count
);

  localparam int MAX_REPORTS = 10;
  localparam int LANE_BITS   = mvt4_pkg::LANE_BITS;
  localparam int NUM_LANES   = mvt4_pkg::NUM_LANES;
  localparam int COLUMN_BITS = mvt4_pkg::COLUMN_BITS;

  typedef mvt4_pkg::lane_vec_t lane_vec_t;

  typedef struct packed {
    lane_vec_t lanes;
    logic      sat;
  } transform_out_t;

  logic [COLUMN_BITS-1:0] matrix_col [NUM_LANES];
  transform_out_t         pending_transforms [$];

  // Take the low ELEMENT_WIDTH bits of a lane as a signed value.
  function automatic longint lane_value(logic [LANE_BITS-1:0] lane);
    logic signed [LANE_BITS-1:0] s;
    s = lane << (LANE_BITS - ELEMENT_WIDTH);
    s = s >>> (LANE_BITS - ELEMENT_WIDTH);
    return longint'(s);
  endfunction

  function automatic transform_out_t transform_vector(lane_vec_t v);
    transform_out_t res;
    longint         acc;
    longint         y;
    longint         hi;
    longint         lo;
    hi = (longint'(1) << (ELEMENT_WIDTH - 1)) - 1;
    lo = -hi - 1;
    res.sat = 1'b0;
    for (int r = 0; r < NUM_LANES; r++) begin
      acc = 0;
      for (int j = 0; j < NUM_LANES; j++)
        acc += lane_value(v[j]) * lane_value(matrix_col[j][r*LANE_BITS +: LANE_BITS]);
      // half an LSB up, then floor: ties go toward plus infinity
      y = (acc + (longint'(1) << (FRACTION_BITS - 1))) >>> FRACTION_BITS;
      if (y > hi) begin
        y = hi;
        res.sat = 1'b1;
      end else if (y < lo) begin
        y = lo;
        res.sat = 1'b1;
      end
      res.lanes[r] = y[LANE_BITS-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    transform_out_t got;
    transform_out_t want;
    logic           bad;
    if (rst) begin
      for (int j = 0; j < NUM_LANES; j++)
        matrix_col[j] = COLUMN_BITS'(longint'(1) << FRACTION_BITS) << (j * LANE_BITS);
      pending_transforms.delete();
    end else begin
      if (done) begin
        got.lanes = {out_w, out_z, out_y, out_x};
        got.sat   = saturated;
        if (pending_transforms.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result with nothing pending: x=%h y=%h z=%h w=%h sat=%b",
                     $realtime, out_x, out_y, out_z, out_w, saturated);
        end else begin
          want = pending_transforms.pop_front();
          bad  = (got.sat !== want.sat);
          for (int r = 0; r < NUM_LANES; r++)
            bad = bad | (got.lanes[r] !== want.lanes[r]);
          if (bad) begin
            fail_count = fail_count + 1;
            if (fail_count <= MAX_REPORTS)
              $display({"%0t: mismatch exp x=%h y=%h z=%h w=%h sat=%b,",
                        " got x=%h y=%h z=%h w=%h sat=%b"},
                       $realtime, want.lanes[0], want.lanes[1], want.lanes[2],
                       want.lanes[3], want.sat, out_x, out_y, out_z, out_w, saturated);
          end
        end
      end
      if (start && !busy)
        pending_transforms.push_back(transform_vector({vec_w, vec_z, vec_y, vec_x}));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mvt4_pkg::CFG_MATRIX_COLUMN_0: matrix_col[0] = cfg_data;
          mvt4_pkg::CFG_MATRIX_COLUMN_1: matrix_col[1] = cfg_data;
          mvt4_pkg::CFG_MATRIX_COLUMN_2: matrix_col[2] = cfg_data;
          mvt4_pkg::CFG_MATRIX_COLUMN_3: matrix_col[3] = cfg_data;
          default: ;
        endcase
      end
    end
    pending = pending_transforms.size();
  end

endmodule

[tb/matrix_vector_transform_4x4_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench top for matrix_vector_transform_4x4_unit: drives vector and config
// beats, gives the verdict. Uses the unit, mvt4_pkg, mvt4_transform_checker.
module matrix_vector_transform_4x4_unit_tb;

  localparam int ELEMENT_WIDTH   = 16;
  localparam int FRACTION_BITS   = 12;
  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 6;
  localparam int MAX_GAP         = 4;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 118;
  localparam int BURST_SPAN      = 32;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES  = 400000;
  localparam int UNIT            = 1 << FRACTION_BITS;

  localparam int LANE_BITS       = mvt4_pkg::LANE_BITS;
  localparam int NUM_LANES       = mvt4_pkg::NUM_LANES;
  localparam int COLUMN_BITS     = mvt4_pkg::COLUMN_BITS;
  localparam int CFG_INDEX_WIDTH = mvt4_pkg::CFG_INDEX_WIDTH;

  typedef mvt4_pkg::lane_vec_t lane_vec_t;

  localparam logic [LANE_BITS-1:0] Q_ONE  = LANE_BITS'(UNIT);
  localparam logic [LANE_BITS-1:0] Q_MAX  = 16'h7fff;
  localparam logic [LANE_BITS-1:0] Q_MIN  = 16'h8000;
  localparam logic [LANE_BITS-1:0] Q_LSB  = 16'h0001;
  localparam logic [LANE_BITS-1:0] Q_ZERO = 16'h0000;

  // First and last register index that maps to no register
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INDEX_UNUSED =
    CFG_INDEX_WIDTH'(mvt4_pkg::CFG_MATRIX_COLUMN_3 + 1);
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INDEX_TOP    = '1;

  typedef enum int {
    ELEM_FULL,
    ELEM_UNIT,
    ELEM_CORNER
  } elem_kind_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic [LANE_BITS-1:0]       vec_x, vec_y, vec_z, vec_w;
  logic                       done;
  logic [LANE_BITS-1:0]       out_x, out_y, out_z, out_w;
  logic                       saturated;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [COLUMN_BITS-1:0]     cfg_data;
  int                         pending;
  int                         fail_count;

  matrix_vector_transform_4x4_unit #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .vec_w     (vec_w),
    .done      (done),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The checker sees every channel as the block does and counts failures.
  mvt4_transform_checker #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .vec_x      (vec_x),
    .vec_y      (vec_y),
    .vec_z      (vec_z),
    .vec_w      (vec_w),
    .done       (done),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_w      (out_w),
    .saturated  (saturated),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("matrix_vector_transform_4x4_unit_tb: FAIL");
    $finish;
  end

  // Lane x sits in the low bits, both for vectors and for matrix columns.
  function automatic lane_vec_t pack_lanes(logic [LANE_BITS-1:0] x, logic [LANE_BITS-1:0] y,
                                           logic [LANE_BITS-1:0] z, logic [LANE_BITS-1:0] w);
    return {w, z, y, x};
  endfunction

  function automatic logic [CFG_INDEX_WIDTH-1:0] column_reg(int j);
    case (j)
      0:       return mvt4_pkg::CFG_MATRIX_COLUMN_0;
      1:       return mvt4_pkg::CFG_MATRIX_COLUMN_1;
      2:       return mvt4_pkg::CFG_MATRIX_COLUMN_2;
      default: return mvt4_pkg::CFG_MATRIX_COLUMN_3;
    endcase
  endfunction

  function automatic logic [LANE_BITS-1:0] rand_elem(elem_kind_t kind);
    case (kind)
      ELEM_FULL: return LANE_BITS'($urandom);
      // within plus or minus 1.0, where sums rarely clamp and rounding shows
      ELEM_UNIT: return LANE_BITS'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
      default: begin
        case ($urandom_range(0, 5))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return Q_ZERO;
          3:       return Q_LSB;
          4:       return '1;
          default: return Q_ONE;
        endcase
      end
    endcase
  endfunction

  // Present one vector beat after a gap and hold it until accepted. start
  // stays high on return so back-to-back beats keep the channel full.
  task automatic send_vec(int gap, lane_vec_t v);
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    vec_x <= v[0];
    vec_y <= v[1];
    vec_z <= v[2];
    vec_w <= v[3];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and hold off until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk) start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // One config beat; only called with the pipeline empty.
  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] index, logic [COLUMN_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic load_matrix(lane_vec_t c0, lane_vec_t c1, lane_vec_t c2, lane_vec_t c3);
    write_reg(mvt4_pkg::CFG_MATRIX_COLUMN_0, c0);
    write_reg(mvt4_pkg::CFG_MATRIX_COLUMN_1, c1);
    write_reg(mvt4_pkg::CFG_MATRIX_COLUMN_2, c2);
    write_reg(mvt4_pkg::CFG_MATRIX_COLUMN_3, c3);
  endtask

  initial begin : stimulus
    lane_vec_t  col;
    lane_vec_t  v;
    lane_vec_t  all_max;
    lane_vec_t  all_min;
    lane_vec_t  all_lsb;
    lane_vec_t  all_zero;
    elem_kind_t kind;
    int         pick;
    int         gap;
    bit         burst;

    all_max  = pack_lanes(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    all_min  = pack_lanes(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    all_lsb  = pack_lanes(Q_LSB, Q_LSB, Q_LSB, Q_LSB);
    all_zero = '0;

    // Every input known from time zero.
    rst       = 1'b1;
    start     = 1'b0;
    vec_x     = '0;
    vec_y     = '0;
    vec_z     = '0;
    vec_w     = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Identity from reset: the vector should pass through unchanged.
    send_vec(0, all_zero);
    send_vec(0, all_max);
    send_vec(1, all_min);
    send_vec(0, pack_lanes(Q_LSB, '1, Q_ONE, -Q_ONE));

    // Every element at the positive end: large vectors clamp both ways.
    wait_drained();
    load_matrix(all_max, all_max, all_max, all_max);
    send_vec(0, all_max);
    send_vec(0, all_min);
    send_vec(2, all_lsb);

    // Every element at the negative end: min times min clamps high.
    wait_drained();
    load_matrix(all_min, all_min, all_min, all_min);
    send_vec(0, all_min);
    send_vec(0, all_max);

    // One LSB in column 0 only: each lane is vec_x / 2^12, which puts
    // exact halves and near-halves on the rounding step.
    wait_drained();
    load_matrix(all_lsb, all_zero, all_zero, all_zero);
    send_vec(0, pack_lanes(16'h0800, Q_MAX, Q_MIN, Q_MAX));
    send_vec(0, pack_lanes(16'hf800, Q_MIN, Q_MAX, Q_MIN));
    send_vec(0, pack_lanes(16'hf7ff, Q_ZERO, Q_ZERO, Q_ZERO));
    send_vec(0, pack_lanes(16'h07ff, Q_ZERO, Q_ZERO, Q_ZERO));
    send_vec(3, pack_lanes(16'h1800, Q_ZERO, Q_ZERO, Q_ZERO));

    // Writes to indexes with no register behind them must change nothing.
    wait_drained();
    write_reg(CFG_INDEX_UNUSED, '1);
    write_reg(CFG_INDEX_TOP, '1);
    send_vec(0, pack_lanes(16'h0800, Q_ZERO, Q_ZERO, Q_ZERO));

    // Random phases, each with its own matrix; the first two stay at the
    // extremes, the rest mix full-range, unit-range and corner elements.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      if ($urandom_range(0, 1) == 0)
        write_reg(CFG_INDEX_WIDTH'($urandom_range(CFG_INDEX_UNUSED, CFG_INDEX_TOP)),
                  {$urandom, $urandom});
      for (int j = 0; j < NUM_LANES; j++) begin
        if (phase == 0) begin
          col = all_max;
        end else if (phase == 1) begin
          col = all_min;
        end else begin
          kind = elem_kind_t'($urandom_range(ELEM_FULL, ELEM_CORNER));
          for (int r = 0; r < NUM_LANES; r++)
            col[r] = rand_elem(kind);
        end
        write_reg(column_reg(j), col);
      end

      for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
        // Re-draw the burst mode now and then so some stretches never idle.
        if (item % BURST_SPAN == 0)
          burst = ($urandom_range(0, 3) == 0);
        gap  = burst ? 0 : $urandom_range(0, MAX_GAP);
        pick = $urandom_range(0, 9);
        kind = (pick < 5) ? ELEM_UNIT : (pick < 8) ? ELEM_FULL : ELEM_CORNER;
        for (int r = 0; r < NUM_LANES; r++)
          v[r] = rand_elem(kind);
        send_vec(gap, v);
        // Occasionally stall the sender until the pipe is empty.
        if ($urandom_range(0, 39) == 0)
          wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("matrix_vector_transform_4x4_unit_tb: PASS");
    else
      $display("matrix_vector_transform_4x4_unit_tb: FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mvt4_pkg.sv
rtl/core/mvt4_lane.sv
rtl/core/mvt4_merge.sv
rtl/core/matrix_vector_transform_4x4_unit.sv
rtl/core/mvt4_checker.sv
tb/mvt4_transform_checker.sv
tb/matrix_vector_transform_4x4_unit_tb.sv
